// ----- sv/ccl_pkg.sv -----
`timescale 1ns / 1ps

package ccl_pkg;

  localparam int MAX_PAIRS_DEF = 32;
  localparam int MAX_DIM_DEF   = 64;

  localparam int VAL_W     = 32;
  localparam int LOSS_W    = 48;
  localparam int LOSS_OUT_W = 31;
  localparam int IDX_W     = 12;
  localparam int PAIRS_W   = 6;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0]   MARGIN_RST = 32'd65536;
  localparam logic [PAIRS_W-1:0] PAIRS_RST  = 6'd32;
  localparam logic [DIM_W-1:0]   DIM_RST    = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MARGIN = 2'd0,
    CFG_PAIRS  = 2'd1,
    CFG_DIM    = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ----- sv/ccl_ifs.sv -----
`timescale 1ns / 1ps

interface ccl_in_if;
  import ccl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [VAL_W-1:0] feature_value;
  logic                    is_last;
  logic [IDX_W-1:0]        read_index;
  logic signed [VAL_W-1:0] upstream_grad;
  modport source (output valid, cmd, feature_value, is_last, read_index, upstream_grad,
                  input ready);
  modport sink (input valid, cmd, feature_value, is_last, read_index, upstream_grad,
                output ready);
endinterface

interface ccl_out_if;
  import ccl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] grad_value;
  logic [LOSS_OUT_W-1:0]   loss_value;
  logic                    status;
  modport source (output valid, grad_value, loss_value, status, input ready);
  modport sink (input valid, grad_value, loss_value, status, output ready);
endinterface

interface ccl_cfg_if;
  import ccl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/ccl_ram.sv -----
`timescale 1ns / 1ps

module ccl_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  localparam int A    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic         clk,
  input  logic         we,
  input  logic [A-1:0] waddr,
  input  logic [W-1:0] wdata,
  input  logic [A-1:0] raddr,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/ccl_div.sv -----
`timescale 1ns / 1ps

module ccl_div #(
  parameter int QW = 48,
  parameter int NW = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [QW:0] dividend,
  input  logic [NW-1:0]      divisor,
  output logic               done,
  output logic signed [QW:0] quotient
);
  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [QW-1:0] mag;
  logic [NW:0]   rem;
  logic          neg;
  logic [NW:0]   rt;
  logic          ge;
  logic signed [QW:0] dabs;
  logic signed [QW:0] qm;

  assign dabs = dividend[QW] ? -dividend : dividend;
  assign rt = {rem[NW-1:0], mag[QW-1]};
  assign ge = rt >= {1'b0, divisor};
  assign qm = $signed({1'b0, mag});
  assign quotient = neg ? -qm : qm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[QW];
        mag  <= dabs[QW-1:0];
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? rt - {1'b0, divisor} : rt;
        mag <= {mag[QW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (32'(cnt) == QW - 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- sv/coupled_clusters_loss.sv -----
`timescale 1ns / 1ps

// coupled clusters loss engine
// items: cmd 0 loads one feature element (positives first, row-major), cmd 1
// reads one gradient element; results: one transfer per read, none per load.
// cfg: margin, pairs_in_use, dim_in_use; the user must write them only while the block
// is idle, as the block itself does not enforce it. the load with is_last starts the
// compute pass, which walks the store with one shared serial divider (QW = 48).
// a read out of range or before the first batch skips the divide and returns status 1.
// items.ready is low during the compute pass and during a read.
// a finished result sits in an output register; the next item is taken while
// it waits, and a second read holds its result until the first is taken.
// reset restores the control and cfg registers and clears the load count and the
// batch flag; the stores are not cleared, and feature entries a batch does not load keep old data.
module coupled_clusters_loss #(
  parameter int MAX_PAIRS = ccl_pkg::MAX_PAIRS_DEF,
  parameter int MAX_DIM   = ccl_pkg::MAX_DIM_DEF
) (
  input logic     clk,
  input logic     rst,
  ccl_in_if.sink  items,
  ccl_out_if.source results,
  ccl_cfg_if.sink cfg
);
  import ccl_pkg::*;

  localparam int NW  = $clog2(MAX_PAIRS + 1);
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int SD  = 2 * MAX_PAIRS * MAX_DIM;
  localparam int AW  = $clog2(SD);
  localparam int PW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int KW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int QW  = (32 + 2 * NW > LOSS_W) ? 32 + 2 * NW : LOSS_W;
  localparam int SW  = 47 + DW;
  localparam int RST_N = (int'(PAIRS_RST) > MAX_PAIRS) ? MAX_PAIRS : int'(PAIRS_RST);
  localparam int RST_D = (int'(DIM_RST) > MAX_DIM) ? MAX_DIM : int'(DIM_RST);
  localparam int ST_W = 25;

  typedef logic signed [QW:0] qv_t;

  typedef enum logic [ST_W-1:0] {
    S_IDLE   = 25'b1 << 0,
    S_CS_RD  = 25'b1 << 1,
    S_CS_AC  = 25'b1 << 2,
    S_CS_DIV = 25'b1 << 3,
    S_DF_RD  = 25'b1 << 4,
    S_DF_WR  = 25'b1 << 5,
    S_HD_RD  = 25'b1 << 6,
    S_HD_MUL = 25'b1 << 7,
    S_HD_ACC = 25'b1 << 8,
    S_HD_END = 25'b1 << 9,
    S_HG_RD  = 25'b1 << 10,
    S_HG_ACC = 25'b1 << 11,
    S_NG_RD  = 25'b1 << 12,
    S_NG_MUL = 25'b1 << 13,
    S_NG_DIV = 25'b1 << 14,
    S_CG_RD  = 25'b1 << 15,
    S_CG_DIV = 25'b1 << 16,
    S_PG_RD  = 25'b1 << 17,
    S_PG_MUL = 25'b1 << 18,
    S_PG_DIV = 25'b1 << 19,
    S_LS_DIV = 25'b1 << 20,
    S_RD_RD  = 25'b1 << 21,
    S_RD_MUL = 25'b1 << 22,
    S_RD_DIV = 25'b1 << 23,
    S_RD_OUT = 25'b1 << 24
  } state_t;

  function automatic logic is_div(input state_t s);
    return s == S_CS_DIV || s == S_NG_DIV || s == S_CG_DIV || s == S_PG_DIV ||
           s == S_LS_DIV || s == S_RD_DIV;
  endfunction

  function automatic logic [LOSS_W-1:0] loss_add(input logic [LOSS_W-1:0] a,
                                                 input logic [LOSS_W-1:0] b);
    logic [LOSS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LOSS_W] ? '1 : s[LOSS_W-1:0];
  endfunction

  state_t state, state_next;
  logic signed [VAL_W-1:0] margin, margin_next;
  logic [PAIRS_W-1:0] pairs, pairs_next;
  logic [DIM_W-1:0] dim, dim_next;
  logic [AW:0] lc, lc_next;
  logic bv, bv_next;
  logic [NW-1:0] bn, bn_next;
  logic [DW-1:0] bd, bd_next;
  logic [AW:0] lim, lim_next;
  logic negp, negp_next;
  logic [PW-1:0] i, i_next, j, j_next;
  logic [KW-1:0] k, k_next;
  logic [NW-1:0] c, c_next;
  logic [AW:0] ptr, ptr_next, rowbase, rowbase_next;
  qv_t acc, acc_next, cgv, cgv_next;
  logic [SW-1:0] sum, sum_next;
  logic signed [63:0] prod, prod_next;
  logic [LOSS_OUT_W-1:0] nd, nd_next;
  logic [LOSS_W-1:0] loss_acc, loss_acc_next;
  logic [LOSS_OUT_W-1:0] loss_q, loss_q_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic signed [VAL_W-1:0] up, up_next, grad_r, grad_r_next;
  logic status_r, status_r_next;
  logic ov, ov_next;
  logic signed [VAL_W-1:0] og, og_next;
  logic [LOSS_OUT_W-1:0] ol, ol_next;
  logic os, os_next;
  logic dstart, dstart_next;

  logic [NW-1:0] eff_n;
  logic [DW-1:0] eff_d;
  logic [AW:0] eff_lim;

  logic fs_we, gs_we, ct_we, ph_we, cg_we;
  logic [AW-1:0] fs_waddr, gs_waddr;
  logic signed [VAL_W-1:0] fs_wdata, gs_wdata, ct_wdata;
  logic signed [VAL_W-1:0] fs_rdata, gs_rdata, ct_rdata;
  logic [LOSS_OUT_W-1:0] ph_wdata, ph_rdata;
  qv_t cg_wdata, cg_rdata;

  qv_t div_dividend, div_q;
  logic div_done;

  logic signed [63:0] sq;
  logic signed [NW+32:0] cp, pgp;
  logic signed [33:0] h;
  logic [SW-1:0] sh;
  logic [LOSS_OUT_W-1:0] hd;
  logic [63:0] pm, pm16;

  logic last_i, last_j, last_k;

  ccl_ram #(.W(VAL_W), .DEPTH(SD)) u_fs (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(ptr[AW-1:0]), .rdata(fs_rdata)
  );
  ccl_ram #(.W(VAL_W), .DEPTH(SD)) u_gs (
    .clk(clk), .we(gs_we), .waddr(gs_waddr), .wdata(gs_wdata),
    .raddr(AW'(rd_idx)), .rdata(gs_rdata)
  );
  ccl_ram #(.W(VAL_W), .DEPTH(MAX_DIM)) u_ct (
    .clk(clk), .we(ct_we), .waddr(k), .wdata(ct_wdata),
    .raddr(k), .rdata(ct_rdata)
  );
  ccl_ram #(.W(LOSS_OUT_W), .DEPTH(MAX_PAIRS)) u_ph (
    .clk(clk), .we(ph_we), .waddr(i), .wdata(ph_wdata),
    .raddr(j), .rdata(ph_rdata)
  );
  ccl_ram #(.W(QW + 1), .DEPTH(MAX_DIM)) u_cg (
    .clk(clk), .we(cg_we), .waddr(k), .wdata(cg_wdata),
    .raddr(k), .rdata(cg_rdata)
  );

  ccl_div #(.QW(QW), .NW(NW)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(div_dividend),
    .divisor(bn), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    if (pairs == '0) eff_n = NW'(1);
    else if (int'(pairs) > MAX_PAIRS) eff_n = NW'(MAX_PAIRS);
    else eff_n = NW'(pairs);
    if (dim == '0) eff_d = DW'(1);
    else if (int'(dim) > MAX_DIM) eff_d = DW'(MAX_DIM);
    else eff_d = DW'(dim);
  end
  assign eff_lim = ((AW + 1)'(eff_n) * (AW + 1)'(eff_d)) << 1;

  assign last_i = int'(i) == int'(bn) - 1;
  assign last_j = int'(j) == int'(bn) - 1;
  assign last_k = int'(k) == int'(bd) - 1;

  assign sq   = fs_rdata * fs_rdata;
  assign cp   = $signed({1'b0, c}) * fs_rdata;
  assign pgp  = $signed({1'b0, bn - 1'b1}) * fs_rdata;
  assign h    = 34'($signed({1'b0, ph_rdata})) + 34'(margin) - 34'($signed({1'b0, nd}));
  assign sh   = sum >> 1;
  assign hd   = (sh > SW'({LOSS_OUT_W{1'b1}})) ? '1 : sh[LOSS_OUT_W-1:0];
  assign pm   = prod[63] ? 64'(-prod) : 64'(prod);
  assign pm16 = pm >> 16;

  always_comb begin
    case (state)
      S_CS_DIV: div_dividend = acc;
      S_NG_DIV: div_dividend = -qv_t'(prod);
      S_CG_DIV: div_dividend = cg_rdata;
      S_PG_DIV: div_dividend = acc;
      S_LS_DIV: div_dividend = qv_t'(loss_acc);
      S_RD_DIV: div_dividend = prod[63] ? -qv_t'(pm16) : qv_t'(pm16);
      default:  div_dividend = '0;
    endcase
  end

  assign items.ready = state == S_IDLE;
  assign cfg.ready = 1'b1;
  assign results.valid = ov;
  assign results.grad_value = og;
  assign results.loss_value = ol;
  assign results.status = os;

  always_comb begin
    state_next = state;
    margin_next = margin;
    pairs_next = pairs;
    dim_next = dim;
    lc_next = lc;
    bv_next = bv;
    bn_next = bn;
    bd_next = bd;
    lim_next = lim;
    negp_next = negp;
    i_next = i;
    j_next = j;
    k_next = k;
    c_next = c;
    ptr_next = ptr;
    rowbase_next = rowbase;
    acc_next = acc;
    cgv_next = cgv;
    sum_next = sum;
    prod_next = prod;
    nd_next = nd;
    loss_acc_next = loss_acc;
    loss_q_next = loss_q;
    rd_idx_next = rd_idx;
    up_next = up;
    grad_r_next = grad_r;
    status_r_next = status_r;
    ov_next = ov && !results.ready;
    og_next = og;
    ol_next = ol;
    os_next = os;
    fs_we = 1'b0;
    fs_waddr = ptr[AW-1:0];
    fs_wdata = '0;
    gs_we = 1'b0;
    gs_waddr = ptr[AW-1:0];
    gs_wdata = sat32(64'(div_q));
    ct_we = 1'b0;
    ct_wdata = div_q[VAL_W-1:0];
    ph_we = 1'b0;
    ph_wdata = hd;
    cg_we = 1'b0;
    cg_wdata = '0;

    if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_MARGIN: margin_next = cfg.data;
        CFG_PAIRS:  pairs_next = cfg.data[PAIRS_W-1:0];
        CFG_DIM:    dim_next = cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end

    unique case (state)
      S_IDLE: begin
        if (items.valid) begin
          if (items.cmd == CMD_LOAD) begin
            if (lc < eff_lim) begin
              fs_we = 1'b1;
              fs_waddr = lc[AW-1:0];
              fs_wdata = items.feature_value;
              lc_next = lc + 1'b1;
            end
            if (items.is_last) begin
              bn_next = eff_n;
              bd_next = eff_d;
              lim_next = eff_lim;
              k_next = '0;
              i_next = '0;
              ptr_next = '0;
              acc_next = '0;
              state_next = S_CS_RD;
            end
          end else begin
            rd_idx_next = items.read_index;
            up_next = items.upstream_grad;
            if (bv && (32'(items.read_index) < 32'(lim))) begin
              state_next = S_RD_RD;
            end else begin
              grad_r_next = '0;
              status_r_next = 1'b1;
              state_next = S_RD_OUT;
            end
          end
        end
      end
      S_CS_RD: state_next = S_CS_AC;
      S_CS_AC: begin
        acc_next = acc + qv_t'(fs_rdata);
        ptr_next = ptr + (AW + 1)'(bd);
        i_next = i + 1'b1;
        state_next = last_i ? S_CS_DIV : S_CS_RD;
      end
      S_CS_DIV: begin
        if (div_done) begin
          ct_we = 1'b1;
          if (last_k) begin
            ptr_next = '0;
            k_next = '0;
            state_next = S_DF_RD;
          end else begin
            k_next = k + 1'b1;
            ptr_next = (AW + 1)'(k) + 1'b1;
            i_next = '0;
            acc_next = '0;
            state_next = S_CS_RD;
          end
        end
      end
      S_DF_RD: state_next = S_DF_WR;
      S_DF_WR: begin
        fs_we = 1'b1;
        fs_wdata = sat32(64'(fs_rdata) - 64'(ct_rdata));
        ptr_next = ptr + 1'b1;
        k_next = last_k ? '0 : k + 1'b1;
        if (ptr == lim - 1'b1) begin
          ptr_next = '0;
          k_next = '0;
          i_next = '0;
          sum_next = '0;
          negp_next = 1'b0;
          loss_acc_next = '0;
          state_next = S_HD_RD;
        end else begin
          state_next = S_DF_RD;
        end
      end
      S_HD_RD: state_next = S_HD_MUL;
      S_HD_MUL: begin
        prod_next = sq;
        state_next = S_HD_ACC;
      end
      S_HD_ACC: begin
        sum_next = sum + SW'(prod[63:16]);
        ptr_next = ptr + 1'b1;
        if (last_k) begin
          state_next = S_HD_END;
        end else begin
          k_next = k + 1'b1;
          state_next = S_HD_RD;
        end
      end
      S_HD_END: begin
        k_next = '0;
        sum_next = '0;
        if (!negp) begin
          ph_we = 1'b1;
          loss_acc_next = loss_add(loss_acc, LOSS_W'(hd));
          if (last_i) begin
            negp_next = 1'b1;
            i_next = '0;
            rowbase_next = ptr;
          end else begin
            i_next = i + 1'b1;
          end
          state_next = S_HD_RD;
        end else begin
          nd_next = hd;
          j_next = '0;
          c_next = '0;
          state_next = S_HG_RD;
        end
      end
      S_HG_RD: state_next = S_HG_ACC;
      S_HG_ACC: begin
        if (!h[33] && h != '0) begin
          c_next = c + 1'b1;
          loss_acc_next = loss_add(loss_acc, LOSS_W'(h[32:0]));
        end
        if (last_j) begin
          k_next = '0;
          ptr_next = rowbase;
          state_next = S_NG_RD;
        end else begin
          j_next = j + 1'b1;
          state_next = S_HG_RD;
        end
      end
      S_NG_RD: state_next = S_NG_MUL;
      S_NG_MUL: begin
        prod_next = 64'(cp);
        cgv_next = cg_rdata;
        state_next = S_NG_DIV;
      end
      S_NG_DIV: begin
        if (div_done) begin
          gs_we = 1'b1;
          cg_we = 1'b1;
          cg_wdata = (i == '0) ? qv_t'(prod) : cgv + qv_t'(prod);
          ptr_next = ptr + 1'b1;
          if (last_k) begin
            k_next = '0;
            if (last_i) begin
              state_next = S_CG_RD;
            end else begin
              i_next = i + 1'b1;
              sum_next = '0;
              rowbase_next = ptr + 1'b1;
              state_next = S_HD_RD;
            end
          end else begin
            k_next = k + 1'b1;
            state_next = S_NG_RD;
          end
        end
      end
      S_CG_RD: state_next = S_CG_DIV;
      S_CG_DIV: begin
        if (div_done) begin
          cg_we = 1'b1;
          cg_wdata = qv_t'(sat32(64'(div_q)));
          if (last_k) begin
            ptr_next = '0;
            k_next = '0;
            state_next = S_PG_RD;
          end else begin
            k_next = k + 1'b1;
            state_next = S_CG_RD;
          end
        end
      end
      S_PG_RD: state_next = S_PG_MUL;
      S_PG_MUL: begin
        acc_next = qv_t'(pgp) + cg_rdata;
        state_next = S_PG_DIV;
      end
      S_PG_DIV: begin
        if (div_done) begin
          gs_we = 1'b1;
          ptr_next = ptr + 1'b1;
          k_next = last_k ? '0 : k + 1'b1;
          state_next = (ptr == (lim >> 1) - 1'b1) ? S_LS_DIV : S_PG_RD;
        end
      end
      S_LS_DIV: begin
        if (div_done) begin
          loss_q_next = (div_q > qv_t'({LOSS_OUT_W{1'b1}})) ? '1 : div_q[LOSS_OUT_W-1:0];
          bv_next = 1'b1;
          lc_next = '0;
          state_next = S_IDLE;
        end
      end
      S_RD_RD: state_next = S_RD_MUL;
      S_RD_MUL: begin
        prod_next = gs_rdata * up;
        state_next = S_RD_DIV;
      end
      S_RD_DIV: begin
        if (div_done) begin
          grad_r_next = sat32(64'(div_q));
          status_r_next = 1'b0;
          state_next = S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        if (!ov || results.ready) begin
          ov_next = 1'b1;
          og_next = grad_r;
          ol_next = loss_q;
          os_next = status_r;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    dstart_next = is_div(state_next) && (state_next != state);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      margin <= MARGIN_RST;
      pairs <= PAIRS_RST;
      dim <= DIM_RST;
      lc <= '0;
      bv <= 1'b0;
      bn <= NW'(RST_N);
      bd <= DW'(RST_D);
      lim <= (AW + 1)'(2 * RST_N * RST_D);
      ptr <= '0;
      loss_acc <= '0;
      loss_q <= '0;
      ov <= 1'b0;
      dstart <= 1'b0;
    end else begin
      state <= state_next;
      margin <= margin_next;
      pairs <= pairs_next;
      dim <= dim_next;
      lc <= lc_next;
      bv <= bv_next;
      bn <= bn_next;
      bd <= bd_next;
      lim <= lim_next;
      ptr <= ptr_next;
      loss_acc <= loss_acc_next;
      loss_q <= loss_q_next;
      ov <= ov_next;
      dstart <= dstart_next;
    end
  end

  always_ff @(posedge clk) begin
    negp <= negp_next;
    i <= i_next;
    j <= j_next;
    k <= k_next;
    c <= c_next;
    rowbase <= rowbase_next;
    acc <= acc_next;
    cgv <= cgv_next;
    sum <= sum_next;
    prod <= prod_next;
    nd <= nd_next;
    rd_idx <= rd_idx_next;
    up <= up_next;
    grad_r <= grad_r_next;
    status_r <= status_r_next;
    og <= og_next;
    ol <= ol_next;
    os <= os_next;
  end

  a_ok_needs_batch: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.status || bv))
    else $error("ok status without a computed batch");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> is_div(state))
    else $error("divider finished outside a divide step");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (ptr <= lim))
    else $error("store pointer beyond batch");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    dstart |-> !items.ready)
    else $error("input ready during a divide");
endmodule
